// ----- rtl/vc565_pkg.sv -----
// Shared widths and defaults for the voice color HSV to RGB565 block.
`timescale 1ns / 1ps
package vc565_pkg;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TAG_W             = 8;
    localparam int ENV_W             = 16;
    localparam int ROSTER_W          = 12;
    localparam int PAIRS_W           = ROSTER_W - 1;
    localparam int COLOR_W           = 16;
endpackage

// ----- rtl/vc565_step.sv -----
// One pipeline stage: one divider quotient bit, and one square-root digit when DO_SQ is set.
`timescale 1ns / 1ps
module vc565_step import vc565_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter bit DO_SQ         = 1'b1,
    parameter int SIDE_W        = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [PAIRS_W-1:0]           pairs,
    input  logic                         in_valid,
    input  logic [2*FRACTION_BITS+1:0]   in_rad,
    input  logic [FRACTION_BITS+1:0]     in_rem,
    input  logic [FRACTION_BITS:0]       in_root,
    input  logic [FRACTION_BITS+6:0]     in_num,
    input  logic [PAIRS_W-1:0]           in_drem,
    input  logic [FRACTION_BITS-1:0]     in_q,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [2*FRACTION_BITS+1:0]   out_rad,
    output logic [FRACTION_BITS+1:0]     out_rem,
    output logic [FRACTION_BITS:0]       out_root,
    output logic [FRACTION_BITS+6:0]     out_num,
    output logic [PAIRS_W-1:0]           out_drem,
    output logic [FRACTION_BITS-1:0]     out_q,
    output logic [SIDE_W-1:0]            out_side
);
    localparam int F = FRACTION_BITS;

    logic              valid_reg;
    logic [2*F+1:0]    rad_reg, rad_next;
    logic [F+1:0]      rem_reg, rem_next;
    logic [F:0]        root_reg, root_next;
    logic [F+6:0]      num_reg;
    logic [PAIRS_W-1:0] drem_reg, drem_next;
    logic [F-1:0]      q_reg, q_next;
    logic [SIDE_W-1:0] side_reg;

    logic [F+3:0]      sq_sh;
    logic [F+3:0]      sq_trial;
    logic              sq_ge;
    logic [PAIRS_W:0]  dv_sh;
    logic              dv_ge;

    always_comb begin
        sq_sh    = {in_rem, in_rad[2*F+1:2*F]};
        sq_trial = {1'b0, in_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
        if (DO_SQ) begin
            rad_next  = in_rad << 2;
            rem_next  = sq_ge ? (F+2)'(sq_sh - sq_trial) : sq_sh[F+1:0];
            root_next = {in_root[F-1:0], sq_ge};
        end else begin
            rad_next  = in_rad;
            rem_next  = in_rem;
            root_next = in_root;
        end
        dv_sh     = {in_drem, in_num[F+6]};
        dv_ge     = dv_sh >= {1'b0, pairs};
        drem_next = dv_ge ? PAIRS_W'(dv_sh - {1'b0, pairs}) : dv_sh[PAIRS_W-1:0];
        q_next    = {in_q[F-2:0], dv_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            num_reg  <= in_num << 1;
            drem_reg <= drem_next;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_num   = num_reg;
    assign out_drem  = drem_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;
endmodule

// ----- rtl/voice_color_hsv_to_rgb565.sv -----
// Top level: voice tag and envelope to an RGB565 color, fully pipelined.
`timescale 1ns / 1ps
// Accepts one request per clock unless the m_ side stalls, and returns one
// color per request, in order. FRACTION_BITS + 7 stages of a shared digit
// pipeline (one bit of the roster hue division per stage, plus one envelope
// square-root digit where DO_SQ is set) feed five stages of multiply and pack.
// A stall on the m_ side holds the whole pipeline; nothing is dropped.
// roster_size may be written only while no request is in flight.
module voice_color_hsv_to_rgb565 import vc565_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ROSTER_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // tag[7:0], envelope[23:8]
    input  logic                s_tuser,   // all_birds
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [COLOR_W-1:0]  m_tdata    // color[15:0]
);
    localparam int F      = FRACTION_BITS;
    localparam int D      = F + 7;
    localparam int SIDE_W = 2*F + 2;
    localparam logic [F:0]   ONE     = (F+1)'(64'd1 << F);
    localparam logic [F-1:0] SAT     = F'(((64'd85 << F) + 64'd50) / 64'd100);
    localparam logic [F:0]   DIM     = (F+1)'(((64'd78 << F) + 64'd50) / 64'd100);
    localparam logic [F-1:0] H_BASE  = F'(((64'd6 << F) + 64'd50) / 64'd100);
    localparam logic [F-1:0] H_STEP  = F'(((64'd21 << F) + 64'd50) / 64'd100);
    localparam logic [F-1:0] QUARTER = F'(64'd1 << (F-2));
    localparam logic [F-1:0] THREEQ  = F'((64'd3 << F) >> 2);
    localparam logic [F-1:0] ONE_M_S = F'((64'd1 << F) - ((64'd85 << F) + 64'd50) / 64'd100);

    logic [ROSTER_W-1:0] roster_reg;
    logic                en;
    logic [PAIRS_W-1:0]  pairs;

    logic               v_c    [0:D];
    logic [2*F+1:0]     rad_c  [0:D];
    logic [F+1:0]       rem_c  [0:D];
    logic [F:0]         root_c [0:D];
    logic [F+6:0]       num_c  [0:D];
    logic [PAIRS_W-1:0] drem_c [0:D];
    logic [F-1:0]       q_c    [0:D];
    logic [SIDE_W-1:0]  side_c [0:D];

    logic [TAG_W-1:0]   tag;
    logic [ENV_W-1:0]   env;
    logic [14:0]        env_c;
    logic [F:0]         val0;
    logic [F-1:0]       hue_fx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roster_reg <= '0;
        end else if (cfg_we) begin
            roster_reg <= cfg_wdata;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign pairs    = (roster_reg[ROSTER_W-1:1] == '0) ? PAIRS_W'(1) : roster_reg[ROSTER_W-1:1];

    always_comb begin
        tag = s_tdata[7:0];
        env = s_tdata[23:8];
        if (env[15]) begin
            env_c = '0;
        end else if (env > 16'd16384) begin
            env_c = 15'd16384;
        end else begin
            env_c = env[14:0];
        end
        val0   = (s_tuser && tag[0]) ? DIM : ONE;
        hue_fx = F'(H_BASE + F'(H_STEP * tag[1:0]));
    end

    assign v_c[0]    = s_tvalid;
    assign rad_c[0]  = (2*F+2)'(env_c) << (2*F-14);
    assign rem_c[0]  = '0;
    assign root_c[0] = '0;
    assign num_c[0]  = {tag[7:1], F'(0)};
    assign drem_c[0] = '0;
    assign q_c[0]    = '0;
    assign side_c[0] = {val0, hue_fx, s_tuser};

    for (genvar i = 0; i < D; i++) begin : g_step
        vc565_step #(
            .FRACTION_BITS(F),
            .DO_SQ        (i <= F),
            .SIDE_W       (SIDE_W)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .pairs    (pairs),
            .in_valid (v_c[i]),
            .in_rad   (rad_c[i]),
            .in_rem   (rem_c[i]),
            .in_root  (root_c[i]),
            .in_num   (num_c[i]),
            .in_drem  (drem_c[i]),
            .in_q     (q_c[i]),
            .in_side  (side_c[i]),
            .out_valid(v_c[i+1]),
            .out_rad  (rad_c[i+1]),
            .out_rem  (rem_c[i+1]),
            .out_root (root_c[i+1]),
            .out_num  (num_c[i+1]),
            .out_drem (drem_c[i+1]),
            .out_q    (q_c[i+1]),
            .out_side (side_c[i+1])
        );
    end

    logic           va_reg, vb_reg, vc_reg, vd_reg, vo_reg;
    logic [F:0]     scale_reg, scale_next;
    logic [F:0]     val0a_reg;
    logic [F-1:0]   huea_reg, huea_next;
    logic [2*F:0]   mul_sq;
    logic [F:0]     valb_reg, valb_next;
    logic [2:0]     secb_reg;
    logic [F-1:0]   fb_reg;
    logic [2*F+1:0] mul_v;
    logic [F+2:0]   h6;
    logic [F:0]     valc_reg;
    logic [2:0]     secc_reg;
    logic [F:0]     pc_reg;
    logic [F-1:0]   sfc_reg, s1fc_reg;
    logic [2*F:0]   mul_p;
    logic [2*F-1:0] mul_sf;
    logic [2*F:0]   mul_s1f;
    logic [F:0]     vald_reg, pd_reg, qd_reg, td_reg;
    logic [2:0]     secd_reg;
    logic [2*F+1:0] mul_q, mul_t;
    logic [F:0]     r_sel, g_sel, b_sel;
    logic [F+8:0]   r_b, g_b, b_b;
    logic [COLOR_W-1:0] color_reg, color_next;

    always_comb begin
        mul_sq     = (2*F+1)'(THREEQ * root_c[D]);
        scale_next = (F+1)'(QUARTER) + mul_sq[2*F:F];
        huea_next  = side_c[D][0] ? q_c[D] : side_c[D][F:1];
        mul_v      = (2*F+2)'(val0a_reg * scale_reg);
        valb_next  = mul_v[2*F:F];
        h6         = (F+3)'(huea_reg * 3'd6);
        mul_p      = (2*F+1)'(valb_reg * ONE_M_S);
        mul_sf     = (2*F)'(SAT * fb_reg);
        mul_s1f    = (2*F+1)'(SAT * (ONE - (F+1)'(fb_reg)));
        mul_q      = (2*F+2)'(valc_reg * (ONE - (F+1)'(sfc_reg)));
        mul_t      = (2*F+2)'(valc_reg * (ONE - (F+1)'(s1fc_reg)));
        case (secd_reg)
            3'd0: begin r_sel = vald_reg; g_sel = td_reg;   b_sel = pd_reg;   end
            3'd1: begin r_sel = qd_reg;   g_sel = vald_reg; b_sel = pd_reg;   end
            3'd2: begin r_sel = pd_reg;   g_sel = vald_reg; b_sel = td_reg;   end
            3'd3: begin r_sel = pd_reg;   g_sel = qd_reg;   b_sel = vald_reg; end
            3'd4: begin r_sel = td_reg;   g_sel = pd_reg;   b_sel = vald_reg; end
            default: begin r_sel = vald_reg; g_sel = pd_reg; b_sel = qd_reg; end
        endcase
        r_b = {r_sel, 8'd0} - (F+9)'(r_sel);
        g_b = {g_sel, 8'd0} - (F+9)'(g_sel);
        b_b = {b_sel, 8'd0} - (F+9)'(b_sel);
        color_next = {r_b[F+7:F+3], g_b[F+7:F+2], b_b[F+7:F+3]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            va_reg <= v_c[D];
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            vo_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scale_reg <= scale_next;
            val0a_reg <= side_c[D][2*F+1:F+1];
            huea_reg  <= huea_next;
            valb_reg  <= valb_next;
            secb_reg  <= h6[F+2:F];
            fb_reg    <= h6[F-1:0];
            valc_reg  <= valb_reg;
            secc_reg  <= secb_reg;
            pc_reg    <= (F+1)'(mul_p[2*F:F]);
            sfc_reg   <= mul_sf[2*F-1:F];
            s1fc_reg  <= mul_s1f[2*F-1:F];
            vald_reg  <= valc_reg;
            secd_reg  <= secc_reg;
            pd_reg    <= pc_reg;
            qd_reg    <= mul_q[2*F:F];
            td_reg    <= mul_t[2*F:F];
            color_reg <= color_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = color_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v_c[1])
        else $error("accepted request lost at first stage");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("pipeline stalled without output backpressure");
    a_hold_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (vd_reg && !en) |=> vd_reg)
        else $error("stage dropped during stall");
endmodule

// ----- tb/sv/voice_color_hsv_to_rgb565_tb.sv -----
// Testbench for the voice color HSV to RGB565 block: random stream checked against a predictor.
`timescale 1ns / 1ps
module voice_color_hsv_to_rgb565_tb;
    import vc565_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam longint ONE = 64'd1 << FB;
    localparam longint SAT = ((64'd85 << FB) + 50) / 100;
    localparam longint DIM = ((64'd78 << FB) + 50) / 100;
    localparam longint HUE_BASE = ((64'd6 << FB) + 50) / 100;
    localparam longint HUE_STEP = ((64'd21 << FB) + 50) / 100;
    localparam int ENV_ONE = 16384;
    localparam int LATENCY = FB + 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [ENV_W-1:0] envelope;
        logic [TAG_W-1:0] tag;
        logic             all_birds;
    } voice_req_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [ROSTER_W-1:0] cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [COLOR_W-1:0]  m_tdata;

    voice_req_t          pending_reqs[$];
    logic [COLOR_W-1:0]  expected_colors[$];
    logic [ROSTER_W-1:0] roster_size;
    int                  error_count = 0;
    int                  color_count = 0;
    int                  idle_pct;
    int                  watchdog;
    logic                s_tready_seen;

    voice_color_hsv_to_rgb565 uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint int_sqrt(longint x);
        longint res;
        longint b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint chan8(longint x);
        return (x * 255) >> FB;
    endfunction

    function automatic logic [COLOR_W-1:0] voice_color(voice_req_t r, logic [ROSTER_W-1:0] rs);
        longint hue, val, env, sq, scale, pairs, h6, sector, f, p, q, t, rd, gr, bl;
        if (r.all_birds) begin
            pairs = rs >> 1;
            if (pairs == 0) pairs = 1;
            hue = (((r.tag >> 1) % pairs) << FB) / pairs;
            val = r.tag[0] ? DIM : ONE;
        end else begin
            hue = HUE_BASE + HUE_STEP * r.tag[1:0];
            val = ONE;
        end
        if (r.envelope[15]) env = 0;
        else if (r.envelope > ENV_ONE) env = ENV_ONE;
        else env = r.envelope;
        sq = int_sqrt(env << (2 * FB - 14));
        scale = (ONE >> 2) + ((((ONE * 3) >> 2) * sq) >> FB);
        val = (val * scale) >> FB;
        h6 = hue * 6;
        sector = h6 >> FB;
        f = h6 & (ONE - 1);
        p = (val * (ONE - SAT)) >> FB;
        q = (val * (ONE - ((SAT * f) >> FB))) >> FB;
        t = (val * (ONE - ((SAT * (ONE - f)) >> FB))) >> FB;
        case (sector)
            0: begin rd = val; gr = t; bl = p; end
            1: begin rd = q; gr = val; bl = p; end
            2: begin rd = p; gr = val; bl = t; end
            3: begin rd = p; gr = q; bl = val; end
            4: begin rd = t; gr = p; bl = val; end
            default: begin rd = val; gr = p; bl = q; end
        endcase
        rd = chan8(rd);
        gr = chan8(gr);
        bl = chan8(bl);
        return COLOR_W'(((rd >> 3) << 11) | ((gr >> 2) << 5) | (bl >> 3));
    endfunction

    task automatic report_mismatch(string what, logic [COLOR_W-1:0] got, logic [COLOR_W-1:0] want);
        $display("error: %s color got %04h want %04h", what, got, want);
        error_count++;
    endtask

    task automatic push_req(logic [TAG_W-1:0] tag, logic [ENV_W-1:0] envelope, logic all_birds);
        voice_req_t r;
        r.tag = tag;
        r.envelope = envelope;
        r.all_birds = all_birds;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_colors.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_roster(logic [ROSTER_W-1:0] v);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        roster_size = v;
    endtask

    // driver: advance on accepted request, change inputs at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    voice_req_t r;
                    r = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {r.envelope, r.tag};
                    s_tuser <= r.all_birds;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        s_tready_seen <= s_tvalid && s_tready;
        if (!aresetn) begin
            watchdog <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                voice_req_t r;
                r.tag = s_tdata[7:0];
                r.envelope = s_tdata[23:8];
                r.all_birds = s_tuser;
                expected_colors.push_back(voice_color(r, roster_size));
            end
            if (m_tvalid && m_tready) begin
                color_count++;
                if (expected_colors.size() == 0)
                    report_mismatch("unexpected", m_tdata, '0);
                else begin
                    logic [COLOR_W-1:0] want;
                    want = expected_colors.pop_front();
                    if (m_tdata !== want) report_mismatch("wrong", m_tdata, want);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d idle cycles", watchdog);
                $display("voice_color_hsv_to_rgb565: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [ROSTER_W-1:0] settings[7];
        logic [ENV_W-1:0] env;
        int roll;
        settings = '{12'd0, 12'd1, 12'd4095, 12'd2, 12'd7, 12'd100, 12'd4094};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        roster_size = '0;
        idle_pct = 33;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset roster, envelope extremes, fixed hues, dimming
        for (int i = 0; i < 4; i++) push_req(TAG_W'(i), 16'h4000, 1'b0);
        push_req(8'hFF, 16'h8000, 1'b0);
        push_req(8'h00, 16'h7FFF, 1'b0);
        push_req(8'h01, 16'h0000, 1'b1);
        push_req(8'hFE, 16'hFFFF, 1'b1);
        push_req(8'h02, 16'h4001, 1'b0);
        push_req(8'h03, 16'h0001, 1'b1);
        drain_and_settle();

        for (int s = 0; s < 7; s++) begin
            write_roster(settings[s]);
            for (int k = 0; k < 6; k++)
                push_req(TAG_W'($urandom_range(255)), 16'(k * 4096), 1'b1);
            drain_and_settle();
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_roster(ph == 5 ? 12'($urandom_range(4095)) : 12'($urandom_range(64)));
            idle_pct = (ph == 2) ? 0 : 33;
            for (int n = 0; n < 110; n++) begin
                roll = $urandom_range(9);
                if (roll < 6) env = ENV_W'($urandom_range(16384));
                else if (roll < 8) env = ENV_W'($urandom_range(65535));
                else env = (roll == 8) ? 16'h4000 : 16'h0000;
                push_req(TAG_W'($urandom_range(255)), env, 1'($urandom_range(1)));
            end
            drain_and_settle();
        end

        $display("covered %0d colors over fixed and roster hues, roster 0 to 4095", color_count);
        $display("envelope clamped at both ends, with random idles on both sides");
        if (error_count == 0)
            $display("voice_color_hsv_to_rgb565: match");
        else
            $display("voice_color_hsv_to_rgb565: mismatch");
        $finish;
    end
endmodule
